// ===== src/holt_trend_forecaster_assert.svh =====
// Assertion macros for the Holt trend forecaster checker.
// Included by the checker file; depends on nothing else.
`ifndef HOLT_TREND_FORECASTER_ASSERT_SVH
`define HOLT_TREND_FORECASTER_ASSERT_SVH
// An implication checked at every rising clock edge outside reset.
`define HTF_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// A next-cycle implication checked outside reset.
`define HTF_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`endif

// ===== src/htf_pkg.sv =====
// Package for the Holt trend forecaster: payload structs, register
// indexes, sequencer states and constants. Depends on nothing.
`default_nettype none
package htf_pkg;
   localparam int MAX_HORIZON_DEF = 64;
   localparam int COUNT_BITS_DEF  = 24;
   localparam logic [16:0] CI_Z_Q16 = 17'd128451;

   localparam logic [1:0] REG_LEVEL_GAIN = 2'd0;
   localparam logic [1:0] REG_TREND_GAIN = 2'd1;
   localparam logic [1:0] REG_HORIZON    = 2'd2;

   typedef struct packed {
      logic signed [31:0] sample;
      logic               last;
   } req_type;

   typedef struct packed {
      logic [6:0]         step;
      logic signed [31:0] forecast;
      logic signed [31:0] low_limit;
      logic signed [31:0] high_limit;
      logic [31:0]        mean_sq_error;
      logic [31:0]        root_mse;
      logic               final_res;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_ERR, ST_SQ, ST_LVL, ST_TRD, ST_DIV, ST_RSQ, ST_FC, ST_SQRT_S,
      ST_W, ST_OUT
   } state_type;
endpackage
`default_nettype wire

// ===== src/holt_trend_forecaster.sv =====
// Holt trend forecaster: sequencer, shared multiplier, divider and square root; uses htf_pkg.
// Each sample passes the accept, error, square, level and trend states, or only accept and
// error for the first two samples of a series; req_stall is high while busy.
// A last sample adds a divide and a root, then per step the FC, SQRT_S, W and OUT states,
// each step waiting until the previous result is taken.
// Reset (synchronous, active high) clears series state and loads register defaults.
`default_nettype none
module holt_trend_forecaster #(
   parameter int MAX_HORIZON = htf_pkg::MAX_HORIZON_DEF,
   parameter int COUNT_BITS  = htf_pkg::COUNT_BITS_DEF
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire htf_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output htf_pkg::rsp_type      rsp_data,
   input  wire logic             psel,
   input  wire logic             penable,
   input  wire logic             pwrite,
   input  wire logic [3:0]       paddr,
   input  wire logic [31:0]      pwdata,
   output logic [31:0]           prdata,
   output logic                  pready
);
   import htf_pkg::*;

   localparam logic [6:0] HMAX = 7'(MAX_HORIZON);
   localparam logic [COUNT_BITS-1:0] CMAX = '1;

   // Configuration registers.
   logic [15:0] alpha_ff, beta_ff;
   logic [6:0]  hor_ff;
   wire cfg_wr = psel & penable & pwrite;
   assign pready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         alpha_ff <= 16'd32768; beta_ff <= 16'd32768; hor_ff <= 7'd8;
      end else if (cfg_wr) begin
         unique case (paddr[3:2])
            REG_LEVEL_GAIN: alpha_ff <= pwdata[15:0];
            REG_TREND_GAIN: beta_ff  <= pwdata[15:0];
            REG_HORIZON:    hor_ff   <= pwdata[6:0];
            default: ;
         endcase
      end
   end
   always_comb begin
      unique case (paddr[3:2])
         REG_LEVEL_GAIN: prdata = {16'd0, alpha_ff};
         REG_TREND_GAIN: prdata = {16'd0, beta_ff};
         REG_HORIZON:    prdata = {25'd0, hor_ff};
         default:        prdata = 32'd0;
      endcase
   end

   // Series state and working registers.
   state_type state_ff, state_in;
   logic signed [31:0] level_ff;
   logic signed [32:0] trend_ff;
   logic [63:0] sse_ff;
   logic [COUNT_BITS-1:0] cnt_ff;
   logic signed [31:0] x_ff;
   logic last_ff;
   logic signed [34:0] err_ff;      // x - pred, or d for the trend update
   logic signed [33:0] pred_ff;     // level + trend
   logic [63:0] prod_ff;            // clamped error magnitude, squared by the shared multiplier
   logic [31:0] mse_ff, rmse_ff;
   logic [6:0] h_ff, steps_ff;
   logic signed [39:0] fc_ff;
   // Shared iteration registers for divide and square root.
   logic [63:0] rem_ff, quo_ff;
   logic [65:0] srem_ff;
   logic [32:0] root_ff;
   logic [63:0] op_ff;
   logic [6:0]  it_ff;
   rsp_type out_ff;
   logic out_v_ff;

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = out_v_ff;
   assign rsp_data  = out_ff;

   // One multiplier: operands chosen by state. The bound width is held on the
   // multiplier through the output cycle, where the result register is loaded.
   logic [32:0] ma;
   logic [32:0] mb;
   logic [65:0] mp;
   always_comb begin
      ma = 33'd0; mb = 33'd0;
      unique case (state_ff)
         ST_SQ:  begin ma = prod_ff[32:0]; mb = prod_ff[32:0]; end
         ST_LVL: begin ma = err_ff[34] ? 33'(-err_ff) : err_ff[32:0];
                       mb = {17'd0, alpha_ff}; end
         ST_TRD: begin ma = err_ff[34] ? 33'(-err_ff) : err_ff[32:0];
                       mb = {17'd0, beta_ff}; end
         ST_W, ST_OUT: begin ma = root_ff; mb = {16'd0, CI_Z_Q16}; end
         default: ;
      endcase
      mp = {33'd0, ma} * {33'd0, mb};
   end

   function automatic logic signed [63:0] rnd(input logic neg, input logic [65:0] m);
      logic [65:0] a;
      a = m - 66'd32768;
      if (!neg) return 64'((m + 66'd32768) >> 16);
      // floor((-m + 2^15)/2^16)
      if (m <= 66'd32768) return 64'd0;
      return -64'((a + 66'd65535) >> 16);
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [39:0] v);
      if (v > 40'sd2147483647) return 32'h7fffffff;
      if (v < -40'sd2147483648) return 32'h80000000;
      return v[31:0];
   endfunction

   logic signed [39:0] lvl_new, trd_new, w_lo, w_hi;
   always_comb begin
      lvl_new = 40'(pred_ff) + 40'(rnd(err_ff[34], mp));
      trd_new = 40'(trend_ff) + 40'(rnd(err_ff[34], mp));
      w_lo = fc_ff - 40'(rnd(1'b0, mp));
      w_hi = fc_ff + 40'(rnd(1'b0, mp));
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (req_valid) state_in = ST_ERR;
         ST_ERR:  state_in = (cnt_ff < 2) ? (last_ff ? ST_DIV : ST_IDLE) : ST_SQ;
         ST_SQ:   state_in = ST_LVL;
         ST_LVL:  state_in = ST_TRD;
         ST_TRD:  state_in = last_ff ? ST_DIV : ST_IDLE;
         ST_DIV:  if (it_ff == 7'd63) state_in = ST_RSQ;
         ST_RSQ:  if (it_ff == 7'd31) state_in = ST_FC;
         ST_FC:   if (!out_v_ff) state_in = ST_SQRT_S;
         ST_SQRT_S: if (it_ff == 7'd31) state_in = ST_W;
         ST_W:    state_in = ST_OUT;
         ST_OUT:  state_in = (h_ff == steps_ff) ? ST_IDLE : ST_FC;
         default: state_in = ST_IDLE;
      endcase
   end

   // Restoring square root step on srem/op.
   logic [65:0] trial, rem_sh;
   always_comb begin
      rem_sh = {srem_ff[63:0], op_ff[63:62]};
      trial  = {root_ff[31:0], 2'b01};
   end
   logic [64:0] dsh;
   logic [COUNT_BITS-1:0] divisor;
   always_comb begin
      divisor = cnt_ff - 1'b1;
      dsh = {rem_ff, quo_ff[63]};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE; out_v_ff <= 1'b0;
         level_ff <= '0; trend_ff <= '0; sse_ff <= '0; cnt_ff <= '0;
      end else begin
         state_ff <= state_in;
         if (out_v_ff && !rsp_stall) out_v_ff <= 1'b0;
         unique case (state_ff)
            ST_IDLE: if (req_valid) begin
               x_ff <= req_data.sample; last_ff <= req_data.last;
            end
            ST_ERR: begin
               if (cnt_ff == 0) begin
                  level_ff <= x_ff; trend_ff <= '0; sse_ff <= '0;
               end else if (cnt_ff == 1) begin
                  trend_ff <= 33'(x_ff) - 33'(level_ff); level_ff <= x_ff;
               end else begin
                  pred_ff <= 34'(level_ff) + 34'(trend_ff);
                  err_ff <= 35'(x_ff) - 35'(level_ff) - 35'(trend_ff);
                  // magnitude clamped to 2^32-1 for squaring
                  begin
                     logic signed [34:0] e;
                     logic [34:0] m;
                     e = 35'(x_ff) - 35'(level_ff) - 35'(trend_ff);
                     m = e[34] ? 35'(-e) : 35'(e);
                     prod_ff <= (m > 35'h0ffffffff) ? 64'h0ffffffff : 64'(m);
                  end
               end
               if (cnt_ff != CMAX) cnt_ff <= cnt_ff + 1'b1;
               it_ff <= '0; rem_ff <= '0;
               quo_ff <= sse_ff;
            end
            ST_SQ: begin
               logic [64:0] inc, s;
               inc = 65'((mp + 66'd32768) >> 16);
               s = {1'b0, sse_ff} + inc;
               sse_ff <= s[64] ? '1 : s[63:0];
            end
            ST_LVL: begin
               level_ff <= sat32(lvl_new);
               err_ff <= 35'(sat32(lvl_new)) - 35'(level_ff) - 35'(trend_ff);
            end
            ST_TRD: begin
               if (trd_new > 40'sh0ffffffff) trend_ff <= 33'h0ffffffff;
               else if (trd_new < -40'sh100000000) trend_ff <= 33'h100000000;
               else trend_ff <= trd_new[32:0];
               it_ff <= '0; rem_ff <= '0; quo_ff <= sse_ff;
            end
            ST_DIV: begin
               if (dsh >= 65'(divisor)) begin
                  rem_ff <= 64'(dsh - 65'(divisor)); quo_ff <= {quo_ff[62:0], 1'b1};
               end else begin
                  rem_ff <= dsh[63:0]; quo_ff <= {quo_ff[62:0], 1'b0};
               end
               it_ff <= (it_ff == 7'd63) ? 7'd0 : it_ff + 1'b1;
               if (it_ff == 7'd63) begin
                  logic [63:0] q;
                  q = (dsh >= 65'(divisor)) ? {quo_ff[62:0], 1'b1} : {quo_ff[62:0], 1'b0};
                  if (cnt_ff < 2) mse_ff <= '0;
                  else mse_ff <= (q > 64'hffffffff) ? 32'hffffffff : q[31:0];
                  op_ff <= (cnt_ff < 2) ? 64'd0 :
                     ((q > 64'hffffffff) ? 64'hffffffff0000 : {16'd0, q[31:0], 16'd0});
                  srem_ff <= '0; root_ff <= '0;
                  h_ff <= 7'd0;
                  steps_ff <= (hor_ff == 0) ? 7'd1 : ((hor_ff > HMAX) ? HMAX : hor_ff);
               end
            end
            ST_RSQ, ST_SQRT_S: begin
               if (rem_sh >= trial) begin
                  srem_ff <= rem_sh - trial; root_ff <= {root_ff[31:0], 1'b1};
               end else begin
                  srem_ff <= rem_sh; root_ff <= {root_ff[31:0], 1'b0};
               end
               op_ff <= {op_ff[61:0], 2'b00};
               it_ff <= it_ff + 1'b1;
               if (state_ff == ST_RSQ && it_ff == 7'd31)
                  rmse_ff <= (rem_sh >= trial) ? {root_ff[30:0], 1'b1} : {root_ff[30:0], 1'b0};
            end
            ST_FC: if (!out_v_ff) begin
               // op = mse*(3+h)*2^15, fits 32+7+15 bits
               fc_ff <= 40'(level_ff) + 40'(trend_ff) * $signed({1'b0, h_ff + 7'd1});
               op_ff <= 64'(39'(mse_ff) * 39'(h_ff + 7'd3)) << 15;
               h_ff <= h_ff + 1'b1;
               it_ff <= '0; srem_ff <= '0; root_ff <= '0;
            end
            ST_W: ;
            ST_OUT: begin
               out_ff.step <= h_ff;
               out_ff.forecast <= sat32(fc_ff);
               out_ff.low_limit <= sat32(w_lo);
               out_ff.high_limit <= sat32(w_hi);
               out_ff.mean_sq_error <= mse_ff;
               out_ff.root_mse <= rmse_ff;
               out_ff.final_res <= (h_ff == steps_ff);
               out_v_ff <= 1'b1;
               if (h_ff == steps_ff) begin
                  level_ff <= '0; trend_ff <= '0; sse_ff <= '0; cnt_ff <= '0;
               end
            end
            default: ;
         endcase
      end
   end
endmodule
`default_nettype wire

// ===== src/htf_checker.sv =====
// Port-level checker for the Holt trend forecaster and its bind.
// Depends on htf_pkg and holt_trend_forecaster_assert.svh.
`default_nettype none
`include "holt_trend_forecaster_assert.svh"
module htf_checker (
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             req_valid,
   input wire logic             req_stall,
   input wire logic             rsp_valid,
   input wire logic             rsp_stall,
   input wire htf_pkg::rsp_type rsp_data
);
   import htf_pkg::*;
   `HTF_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data))
   `HTF_ASSERT_IMPL(a_busy_out, clock, reset, rsp_valid && !rsp_data.final_res, req_stall)
   `HTF_ASSERT_IMPL(a_step_ok, clock, reset, rsp_valid, rsp_data.step != 7'd0)
   `HTF_ASSERT_IMPL(a_bounds, clock, reset, rsp_valid, rsp_data.low_limit <= rsp_data.high_limit)
endmodule
bind holt_trend_forecaster htf_checker u_htf_checker (.*);
`default_nettype wire
